// File: src/trsc_pkg.sv
// ----------------------------------------------------------------------------
// trsc_pkg
// Shared codes and controller/datapath interface types for the two-register
// stack cpu core.
// ----------------------------------------------------------------------------
package trsc_pkg;

	// item operations
	localparam logic [1:0] OPER_LOAD    = 2'd0;
	localparam logic [1:0] OPER_EXEC    = 2'd1;
	localparam logic [1:0] OPER_RESTART = 2'd2;
	localparam logic [1:0] OPER_NOP     = 2'd3;

	// run status codes
	localparam logic [2:0] ST_RUN     = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_MEMERR  = 3'd3;
	localparam logic [2:0] ST_PASTEND = 3'd4;

	// opcodes
	localparam logic [7:0] OPC_LDC    = 8'd0;
	localparam logic [7:0] OPC_ADC    = 8'd1;
	localparam logic [7:0] OPC_LDL    = 8'd2;
	localparam logic [7:0] OPC_STL    = 8'd3;
	localparam logic [7:0] OPC_LDNL   = 8'd4;
	localparam logic [7:0] OPC_STNL   = 8'd5;
	localparam logic [7:0] OPC_ADD    = 8'd6;
	localparam logic [7:0] OPC_SUB    = 8'd7;
	localparam logic [7:0] OPC_SHL    = 8'd8;
	localparam logic [7:0] OPC_SHR    = 8'd9;
	localparam logic [7:0] OPC_ADJ    = 8'd10;
	localparam logic [7:0] OPC_A2SP   = 8'd11;
	localparam logic [7:0] OPC_SP2A   = 8'd12;
	localparam logic [7:0] OPC_CALL   = 8'd13;
	localparam logic [7:0] OPC_RETURN = 8'd14;
	localparam logic [7:0] OPC_BRZ    = 8'd15;
	localparam logic [7:0] OPC_BRLZ   = 8'd16;
	localparam logic [7:0] OPC_BR     = 8'd17;
	localparam logic [7:0] OPC_HALT   = 8'd18;
	localparam logic [7:0] OPC_INV_A  = 8'd19;
	localparam logic [7:0] OPC_INV_B  = 8'd20;

	// configuration register index (word select bit of paddr)
	localparam logic REG_PROGRAM_LENGTH = 1'b0;

	typedef struct packed {
		logic load;
		logic restart;
		logic fetch;
		logic set_past;
		logic mem_read;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic stopped;
		logic past_limit;
		logic load_op;
	} stat_t;

endpackage

// File: src/trsc_ram.sv
// ----------------------------------------------------------------------------
// trsc_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module trsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/trsc_ctrl.sv
// ----------------------------------------------------------------------------
// trsc_ctrl
// Sequencer: accepts items, steps fetch and data access, strobes results.
// ----------------------------------------------------------------------------
module trsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            operation,
	input  trsc_pkg::stat_t       stat,
	output trsc_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_MEM   = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   done_q;
	logic   finish;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					finish = 1'b1;
					unique case (operation)
						trsc_pkg::OPER_LOAD: begin
							cmd.load = 1'b1;
						end
						trsc_pkg::OPER_RESTART: begin
							cmd.restart = 1'b1;
						end
						trsc_pkg::OPER_NOP: begin
						end
						trsc_pkg::OPER_EXEC: begin
							priority if (stat.stopped) begin
							end else if (stat.past_limit) begin
								cmd.set_past = 1'b1;
							end else begin
								cmd.fetch = 1'b1;
								finish    = 1'b0;
								state_d   = S_FETCH;
							end
						end
					endcase
				end
			end
			S_FETCH: begin
				if (stat.load_op) begin
					cmd.mem_read = 1'b1;
					state_d      = S_MEM;
				end else begin
					cmd.exec = 1'b1;
					finish   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_MEM: begin
				cmd.exec = 1'b1;
				finish   = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// File: src/trsc_datapath.sv
// ----------------------------------------------------------------------------
// trsc_datapath
// Architectural registers, code and data images, decode and execute logic.
// ----------------------------------------------------------------------------
module trsc_datapath #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trsc_pkg::cmd_t        cmd,
	output trsc_pkg::stat_t       stat,
	input  logic [9:0]            address,
	input  logic [31:0]           data,
	input  logic [10:0]           program_length,
	output logic [2:0]            status,
	output logic [31:0]           pc_value,
	output logic [31:0]           acc_a,
	output logic [31:0]           acc_b,
	output logic [31:0]           stack_ptr,
	output logic [31:0]           executed_count
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [31:0] DEPTH32 = 32'(MEM_DEPTH);

	logic [31:0] pc_q, a_q, b_q, sp_q, count_q;
	logic [2:0]  status_q;

	logic [31:0] code_word, mem_word;
	logic [31:0] limit, limit_m1, load_addr;
	logic [7:0]  opc;
	logic [31:0] v, ea_base, ea;
	logic        mem_op, mem_fault, load_ok;
	logic        code_we, data_we, store_we;
	logic [AW-1:0] data_waddr;
	logic [31:0] data_wdata;

	logic [31:0] a_n, b_n, sp_n, pc_t, pc_n;
	logic [2:0]  stop_n;

	// images
	assign load_addr = 32'(address);
	assign load_ok   = cmd.load && (load_addr < DEPTH32);
	assign code_we   = load_ok;

	trsc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_code (
		.clk   (clk),
		.we    (code_we),
		.waddr (load_addr[AW-1:0]),
		.wdata (data),
		.re    (cmd.fetch),
		.raddr (pc_q[AW-1:0]),
		.rdata (code_word)
	);

	assign data_we    = load_ok || store_we;
	assign data_waddr = load_ok ? load_addr[AW-1:0] : ea[AW-1:0];
	assign data_wdata = load_ok ? data : ((opc == trsc_pkg::OPC_STL) ? a_q : b_q);

	trsc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (cmd.mem_read),
		.raddr (ea[AW-1:0]),
		.rdata (mem_word)
	);

	// decode
	assign limit    = (32'(program_length) < DEPTH32) ? 32'(program_length) : DEPTH32;
	assign limit_m1 = limit - 32'd1;
	assign opc      = code_word[7:0];
	assign v        = {{8{code_word[31]}}, code_word[31:8]};
	assign ea_base  = ((opc == trsc_pkg::OPC_LDL) || (opc == trsc_pkg::OPC_STL)) ? sp_q : a_q;
	assign ea       = ea_base + v;
	assign mem_op   = (opc == trsc_pkg::OPC_LDL) || (opc == trsc_pkg::OPC_STL)
		|| (opc == trsc_pkg::OPC_LDNL) || (opc == trsc_pkg::OPC_STNL);
	assign mem_fault = mem_op && (ea >= DEPTH32);
	assign store_we  = cmd.exec && !mem_fault
		&& ((opc == trsc_pkg::OPC_STL) || (opc == trsc_pkg::OPC_STNL));

	assign stat.stopped    = (status_q != trsc_pkg::ST_RUN);
	assign stat.past_limit = (pc_q >= limit);
	assign stat.load_op    = !mem_fault
		&& ((opc == trsc_pkg::OPC_LDL) || (opc == trsc_pkg::OPC_LDNL));

	// execute
	always_comb begin
		a_n    = a_q;
		b_n    = b_q;
		sp_n   = sp_q;
		pc_t   = pc_q;
		pc_n   = pc_q;
		stop_n = trsc_pkg::ST_RUN;
		if (mem_fault) begin
			stop_n = trsc_pkg::ST_MEMERR;
		end else begin
			unique case (opc)
				trsc_pkg::OPC_LDC: begin
					b_n = a_q;
					a_n = v;
				end
				trsc_pkg::OPC_ADC:  a_n = a_q + v;
				trsc_pkg::OPC_LDL: begin
					b_n = a_q;
					a_n = mem_word;
				end
				trsc_pkg::OPC_STL:  a_n = b_q;
				trsc_pkg::OPC_LDNL: a_n = mem_word;
				trsc_pkg::OPC_STNL: begin
				end
				trsc_pkg::OPC_ADD:  a_n = b_q + a_q;
				trsc_pkg::OPC_SUB:  a_n = b_q - a_q;
				trsc_pkg::OPC_SHL: begin
					a_n = (a_q >= 32'd32) ? 32'd0 : (b_q << a_q[4:0]);
				end
				trsc_pkg::OPC_SHR: begin
					a_n = (a_q >= 32'd32) ? {32{b_q[31]}}
						: 32'($signed(b_q) >>> a_q[4:0]);
				end
				trsc_pkg::OPC_ADJ:  sp_n = sp_q + v;
				trsc_pkg::OPC_A2SP: begin
					sp_n = a_q;
					a_n  = b_q;
				end
				trsc_pkg::OPC_SP2A: begin
					b_n = a_q;
					a_n = sp_q;
				end
				trsc_pkg::OPC_CALL: begin
					b_n  = a_q;
					a_n  = pc_q;
					pc_t = pc_q + v;
				end
				trsc_pkg::OPC_RETURN: begin
					pc_t = a_q;
					a_n  = b_q;
				end
				trsc_pkg::OPC_BRZ: begin
					if (a_q == 32'd0) begin
						pc_t = pc_q + v;
					end
				end
				trsc_pkg::OPC_BRLZ: begin
					if (a_q[31]) begin
						pc_t = pc_q + v;
					end
				end
				trsc_pkg::OPC_BR:   pc_t = pc_q + v;
				trsc_pkg::OPC_HALT: stop_n = trsc_pkg::ST_HALT;
				trsc_pkg::OPC_INV_A,
				trsc_pkg::OPC_INV_B: stop_n = trsc_pkg::ST_INVALID;
				default: begin
				end
			endcase
			if (stop_n == trsc_pkg::ST_RUN) begin
				if (pc_t >= limit_m1) begin
					stop_n = trsc_pkg::ST_PASTEND;
					pc_n   = pc_t;
				end else begin
					pc_n = pc_t + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			sp_q     <= '0;
			count_q  <= '0;
			status_q <= trsc_pkg::ST_RUN;
		end else begin
			if (cmd.restart) begin
				pc_q     <= '0;
				a_q      <= '0;
				b_q      <= '0;
				sp_q     <= '0;
				status_q <= trsc_pkg::ST_RUN;
			end else if (cmd.set_past) begin
				status_q <= trsc_pkg::ST_PASTEND;
			end else if (cmd.exec) begin
				pc_q     <= pc_n;
				a_q      <= a_n;
				b_q      <= b_n;
				sp_q     <= sp_n;
				status_q <= stop_n;
				count_q  <= count_q + 32'd1;
			end
		end
	end

	assign status         = status_q;
	assign pc_value       = pc_q;
	assign acc_a          = a_q;
	assign acc_b          = b_q;
	assign stack_ptr      = sp_q;
	assign executed_count = count_q;

endmodule

// File: src/two_register_stack_cpu_core.sv
// ----------------------------------------------------------------------------
// two_register_stack_cpu_core
// Two-register accumulator cpu with code and data images, program loading,
// single-step execution and a status/register snapshot per item.
//
// channel   direction  handshake                  payload
// command   in         start & !busy              operation, address, data
// result    out        done (one cycle)           status, pc_value, acc_a, acc_b,
//                                                 stack_ptr, executed_count
// config    in         psel & penable & pwrite    paddr, pwdata (prdata on read)
//
// load, restart, no-op and stopped or past-limit executes: done shows the
// cycle after accept. execute: code fetch through the code image read port,
// then execute; an in-range ldl or ldnl adds one data image read before it.
// busy is high only while an execute is in flight; the next item may be
// accepted in the cycle done is shown, and the receiver cannot stall done.
// reset clears registers, status and count; image contents are undefined.
// ----------------------------------------------------------------------------
module two_register_stack_cpu_core #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [9:0]         address,
	input  logic signed [31:0] data,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] pc_value,
	output logic signed [31:0] acc_a,
	output logic signed [31:0] acc_b,
	output logic signed [31:0] stack_ptr,
	output logic [31:0]        executed_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	trsc_pkg::cmd_t  cmd;
	trsc_pkg::stat_t stat;
	logic [10:0]     prog_len_q;
	logic [31:0]     pc_w, a_w, b_w, sp_w;
	logic            reg_hit;

	// configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == trsc_pkg::REG_PROGRAM_LENGTH);
	assign prdata  = reg_hit ? 32'(prog_len_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			prog_len_q <= pwdata[10:0];
		end
	end

	trsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	trsc_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.address        (address),
		.data           (data),
		.program_length (prog_len_q),
		.status         (status),
		.pc_value       (pc_w),
		.acc_a          (a_w),
		.acc_b          (b_w),
		.stack_ptr      (sp_w),
		.executed_count (executed_count)
	);

	assign pc_value  = $signed(pc_w);
	assign acc_a     = $signed(a_w);
	assign acc_b     = $signed(b_w);
	assign stack_ptr = $signed(sp_w);

endmodule
